// ----- src/mshd_pkg.sv -----
package mshd_pkg;

    // Header layout
    localparam logic [15:0] HDR_SIZE       = 16'd17;
    localparam logic [4:0]  IDX_VERSION    = 5'd4;
    localparam logic [4:0]  IDX_TYPE       = 5'd5;
    localparam logic [4:0]  IDX_SEQUENCE   = 5'd6;
    localparam logic [4:0]  IDX_LENGTH_HI  = 5'd7;
    localparam logic [4:0]  IDX_LENGTH_LO  = 5'd8;
    localparam logic [4:0]  IDX_LAST       = 5'd16;

    // Configuration register defaults and index width
    localparam int unsigned CFG_INDEX_W      = 2;
    localparam logic [31:0] MAGIC_WORD_RESET = 32'h514C_4350;
    localparam logic [7:0]  VERSION_RESET    = 8'd3;

    // Output tdata width: type, sequence, length, timestamp, payload byte
    localparam int unsigned TDATA_W = 104;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAGIC_WORD       = 2'd0,
        REG_PROTOCOL_VERSION = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_HEADER      = 2'd0,
        KIND_PAYLOAD     = 2'd1,
        KIND_VERSION_ERR = 2'd2,
        KIND_LENGTH_ERR  = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   msg_type;
        logic [7:0]   sequence_number;
        logic [15:0]  total_len;
        logic [63:0]  stamp_us;
        logic [7:0]   payload_byte;
        logic         packet_end;
    } result_t;

endpackage

// ----- src/mshd_parser.sv -----
module mshd_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    input  logic [31:0]           magic_word,
    input  logic [7:0]            protocol_version,
    output logic                  res_valid,
    output mshd_pkg::result_t     res
);

    mshd_pkg::phase_t phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [4:0]  idx_reg, idx_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic [63:0] ts_reg, ts_next;
    logic [15:0] remaining_reg, remaining_next;

    logic [31:0] hunt_word;
    logic        last_payload;
    logic        abort;

    assign hunt_word    = {window_reg, rx_byte};
    assign last_payload = (remaining_reg <= 16'd1);

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        idx_next       = idx_reg;
        type_next      = type_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        ts_next        = ts_reg;
        remaining_next = remaining_reg;
        abort          = 1'b0;
        res_valid      = 1'b0;
        res            = '0;

        unique case (phase_reg)
            mshd_pkg::PH_PAYLOAD:
            begin
                // pass the byte through, close the packet on the last one
                res_valid        = 1'b1;
                res.kind         = mshd_pkg::KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.packet_end   = last_payload;
                if (last_payload)
                begin
                    remaining_next = '0;
                    phase_next     = mshd_pkg::PH_HUNT;
                    idx_next       = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - 16'd1;
                end
            end
            mshd_pkg::PH_HEADER:
            begin
                if (idx_reg < mshd_pkg::IDX_VERSION || idx_reg > mshd_pkg::IDX_LAST)
                begin
                    // stray index: hunt the byte
                    if (hunt_word == magic_word)
                    begin
                        window_next = '0;
                        phase_next  = mshd_pkg::PH_HEADER;
                        idx_next    = mshd_pkg::IDX_VERSION;
                    end
                    else
                    begin
                        window_next = hunt_word[23:0];
                        phase_next  = mshd_pkg::PH_HUNT;
                    end
                end
                else
                begin
                    // capture header fields
                    case (idx_reg)
                        mshd_pkg::IDX_VERSION:
                        begin
                            if (rx_byte != protocol_version)
                            begin
                                abort          = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = mshd_pkg::KIND_VERSION_ERR;
                                res.packet_end = 1'b1;
                            end
                        end
                        mshd_pkg::IDX_TYPE:      type_next = rx_byte;
                        mshd_pkg::IDX_SEQUENCE:  seq_next  = rx_byte;
                        mshd_pkg::IDX_LENGTH_HI: len_next  = {rx_byte, 8'h00};
                        mshd_pkg::IDX_LENGTH_LO:
                        begin
                            len_next = {len_reg[15:8], rx_byte};
                            if ({len_reg[15:8], rx_byte} < mshd_pkg::HDR_SIZE)
                            begin
                                abort               = 1'b1;
                                res_valid           = 1'b1;
                                res.kind            = mshd_pkg::KIND_LENGTH_ERR;
                                res.msg_type        = type_reg;
                                res.sequence_number = seq_reg;
                                res.total_len       = {len_reg[15:8], rx_byte};
                                res.packet_end      = 1'b1;
                            end
                        end
                        default:                 ts_next = {ts_reg[55:0], rx_byte};
                    endcase

                    if (abort)
                    begin
                        phase_next = mshd_pkg::PH_HUNT;
                        idx_next   = '0;
                    end
                    else if (idx_reg == mshd_pkg::IDX_LAST)
                    begin
                        // header complete: report it and arm the payload count
                        remaining_next      = len_reg - mshd_pkg::HDR_SIZE;
                        idx_next            = '0;
                        res_valid           = 1'b1;
                        res.kind            = mshd_pkg::KIND_HEADER;
                        res.msg_type        = type_reg;
                        res.sequence_number = seq_reg;
                        res.total_len       = len_reg;
                        res.stamp_us        = ts_next;
                        res.packet_end      = (len_reg == mshd_pkg::HDR_SIZE);
                        phase_next          = (len_reg == mshd_pkg::HDR_SIZE) ?
                                              mshd_pkg::PH_HUNT : mshd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                // slide the window and compare against the sync word
                if (hunt_word == magic_word)
                begin
                    window_next = '0;
                    phase_next  = mshd_pkg::PH_HEADER;
                    idx_next    = mshd_pkg::IDX_VERSION;
                end
                else
                begin
                    window_next = hunt_word[23:0];
                    phase_next  = mshd_pkg::PH_HUNT;
                end
            end
        endcase
    end

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mshd_pkg::PH_HUNT;
            window_reg    <= '0;
            idx_reg       <= '0;
            type_reg      <= '0;
            seq_reg       <= '0;
            len_reg       <= '0;
            ts_reg        <= '0;
            remaining_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            idx_reg       <= idx_next;
            type_reg      <= type_next;
            seq_reg       <= seq_next;
            len_reg       <= len_next;
            ts_reg        <= ts_next;
            remaining_reg <= remaining_next;
        end
    end

    // Payload phase always has at least one byte left to pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mshd_pkg::PH_PAYLOAD) |-> (remaining_reg != 16'd0))
        else $error("payload phase with zero bytes remaining");

    // Header index stays inside the header while collecting it
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mshd_pkg::PH_HEADER) |->
        (idx_reg >= mshd_pkg::IDX_VERSION && idx_reg <= mshd_pkg::IDX_LAST))
        else $error("header index out of range");

endmodule

// ----- src/magic_sync_header_deframer_unit.sv -----
// A result is registered in the output stage before it appears on m_axis.
// Throughput: one input item per cycle while s_axis_tready is high; all results share one output stage.
// A two-entry output stage (result register plus skid register) keeps s_axis_tready
// registered; input stalls while the skid register is full.
// Reset (rst_n low, asynchronous) returns to hunting with an empty window and
// restores the sync word and protocol version to their defaults.
module magic_sync_header_deframer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mshd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data,
    // input byte stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // rx_byte
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // msg_type[7:0], sequence_number[15:8], total_len[31:16],
    // stamp_us[95:32], payload_byte[103:96]
    output logic [mshd_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,   // result_kind
    output logic                                m_axis_tlast    // packet_end
);

    logic [31:0] magic_word_reg;
    logic [7:0]  version_reg;

    logic               in_accept;
    logic               res_valid;
    mshd_pkg::result_t  res;
    logic               push;

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    mshd_pkg::result_t  out_reg, out_next;
    mshd_pkg::result_t  skid_reg, skid_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= mshd_pkg::MAGIC_WORD_RESET;
            version_reg    <= mshd_pkg::VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mshd_pkg::REG_MAGIC_WORD:       magic_word_reg <= cfg_data;
                mshd_pkg::REG_PROTOCOL_VERSION: version_reg    <= cfg_data[7:0];
                default:                        ;
            endcase
        end
    end

    // Parser core
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mshd_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_accept      (in_accept),
        .rx_byte          (s_axis_tdata),
        .magic_word       (magic_word_reg),
        .protocol_version (version_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    assign push = in_accept && res_valid;

    // Output register and skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            // drain skid into the output register when the sink takes an item
            if (m_axis_tready)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Drive result ports
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.packet_end;
    assign m_axis_tdata  = {out_reg.payload_byte, out_reg.stamp_us,
                            out_reg.total_len, out_reg.sequence_number,
                            out_reg.msg_type};

    // Skid entry only ever backs up a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    // A result produced while the output stage is full lands in the skid
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    // Aborts always close the packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == mshd_pkg::KIND_VERSION_ERR ||
                           out_reg.kind == mshd_pkg::KIND_LENGTH_ERR))
        |-> out_reg.packet_end)
        else $error("abort result without packet end");

endmodule
